### hw/rtl/ucs_pkg.sv
// types, character constants and helper functions for the url component splitter
`default_nettype none
package ucs_pkg;

  typedef enum logic [2:0] {
    PH_SCHEME = 3'd0,
    PH_SEP1   = 3'd1,
    PH_SEP2   = 3'd2,
    PH_HOST   = 3'd3,
    PH_PATH   = 3'd4,
    PH_QUERY  = 3'd5,
    PH_FRAG   = 3'd6,
    PH_DEAD   = 3'd7
  } ucs_phase_t;

  localparam logic [1:0] COMP_HOST  = 2'd0;
  localparam logic [1:0] COMP_PATH  = 2'd1;
  localparam logic [1:0] COMP_QUERY = 2'd2;
  localparam logic [1:0] COMP_FRAG  = 2'd3;

  localparam logic [1:0] SCHEME_NONE  = 2'd0;
  localparam logic [1:0] SCHEME_HTTP  = 2'd1;
  localparam logic [1:0] SCHEME_HTTPS = 2'd2;
  localparam logic [1:0] SCHEME_FTP   = 2'd3;

  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  localparam logic [3:0] SCHEME_LEN [3] = '{4'd4, 4'd5, 4'd3};
  localparam logic [3:0] POS_MAX = 4'd15;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_url;
  } ucs_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] component;
    logic       is_status;
    logic       url_valid;
    logic [1:0] scheme_code;
  } ucs_result_t;

  // one step of the front end: an optional data byte and an optional status
  typedef struct packed {
    logic       has_data;
    logic [7:0] data_byte;
    logic [1:0] comp;
    logic       has_status;
    logic       status_valid;
    logic [1:0] status_scheme;
  } ucs_work_t;

  // {ok, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_kept(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                      8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26, 8'h3D,
                      8'h2B, 8'h24, 8'h2C, 8'h2D, 8'h5F, 8'h2E, 8'h21,
                      8'h7E, 8'h2A, 8'h27, 8'h28, 8'h29});
  endfunction

  function automatic logic [7:0] scheme_char(input logic [1:0] k, input logic [3:0] pos);
    logic [7:0] r;
    r = 8'h00;
    case (k)
      2'd0: begin
        case (pos)
          4'd0: r = 8'h68;
          4'd1: r = 8'h74;
          4'd2: r = 8'h74;
          4'd3: r = 8'h70;
          default: r = 8'h00;
        endcase
      end
      2'd1: begin
        case (pos)
          4'd0: r = 8'h68;
          4'd1: r = 8'h74;
          4'd2: r = 8'h74;
          4'd3: r = 8'h70;
          4'd4: r = 8'h73;
          default: r = 8'h00;
        endcase
      end
      2'd2: begin
        case (pos)
          4'd0: r = 8'h66;
          4'd1: r = 8'h74;
          4'd2: r = 8'h70;
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ucs_front.sv
// front end: percent decoding, scheme match and component split, one byte per cycle while step is high
`default_nettype none
module ucs_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire ucs_pkg::ucs_item_t  item,
  output ucs_pkg::ucs_work_t       work,
  output logic                     work_wr
);

  ucs_pkg::ucs_phase_t phase, phase_next;
  logic [3:0] scheme_position, scheme_position_next;
  logic [2:0] scheme_candidates, scheme_candidates_next;
  logic [1:0] escape_step, escape_step_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       error_seen, error_seen_next;
  logic [1:0] matched_scheme, matched_scheme_next;
  logic       byte_after_separator, byte_after_separator_next;

  logic       feed_en;
  logic [7:0] feed_char;
  logic [7:0] lc;
  logic [7:0] dec;
  logic [4:0] hv;
  logic [2:0] live;
  logic       valid;

  always_comb begin
    phase_next                = phase;
    scheme_position_next      = scheme_position;
    scheme_candidates_next    = scheme_candidates;
    escape_step_next          = escape_step;
    high_nibble_next          = high_nibble;
    error_seen_next           = error_seen;
    matched_scheme_next       = matched_scheme;
    byte_after_separator_next = byte_after_separator;
    feed_en   = 1'b0;
    feed_char = item.in_byte;
    hv        = ucs_pkg::hex_value(item.in_byte);
    dec       = {high_nibble, hv[3:0]};
    lc        = 8'h00;
    live      = 3'b000;
    valid     = 1'b0;
    work      = '0;

    // percent decoder
    if (!error_seen && phase != ucs_pkg::PH_DEAD) begin
      case (escape_step)
        ucs_pkg::ESC_IDLE: begin
          if (item.in_byte == ucs_pkg::CH_PERCENT) begin
            escape_step_next = ucs_pkg::ESC_HIGH;
          end else begin
            feed_en = 1'b1;
          end
        end
        ucs_pkg::ESC_HIGH: begin
          if (!hv[4]) begin
            error_seen_next  = 1'b1;
            escape_step_next = ucs_pkg::ESC_IDLE;
            phase_next       = ucs_pkg::PH_DEAD;
          end else begin
            high_nibble_next = hv[3:0];
            escape_step_next = ucs_pkg::ESC_LOW;
          end
        end
        default: begin
          if (!hv[4]) begin
            error_seen_next  = 1'b1;
            escape_step_next = ucs_pkg::ESC_IDLE;
            phase_next       = ucs_pkg::PH_DEAD;
          end else begin
            escape_step_next = ucs_pkg::ESC_IDLE;
            feed_char        = dec;
            feed_en          = ucs_pkg::is_kept(dec);
          end
        end
      endcase
    end

    // parser
    if (feed_en) begin
      case (phase)
        ucs_pkg::PH_SCHEME: begin
          if (feed_char == ucs_pkg::CH_COLON) begin
            phase_next = ucs_pkg::PH_DEAD;
            for (int k = 0; k < 3; k++) begin
              if (scheme_candidates[k] && ucs_pkg::SCHEME_LEN[k] == scheme_position) begin
                matched_scheme_next = 2'(k + 1);
                phase_next          = ucs_pkg::PH_SEP1;
              end
            end
          end else begin
            lc = (feed_char inside {[8'h41:8'h5A]}) ? feed_char + 8'h20 : feed_char;
            for (int k = 0; k < 3; k++) begin
              live[k] = scheme_candidates[k] && (scheme_position < ucs_pkg::SCHEME_LEN[k]) &&
                        (lc == ucs_pkg::scheme_char(2'(k), scheme_position));
            end
            scheme_candidates_next = live;
            if (scheme_position != ucs_pkg::POS_MAX) begin
              scheme_position_next = scheme_position + 4'd1;
            end
            if (live == 3'b000) begin
              phase_next = ucs_pkg::PH_DEAD;
            end
          end
        end
        ucs_pkg::PH_SEP1: begin
          phase_next = (feed_char == ucs_pkg::CH_SLASH) ? ucs_pkg::PH_SEP2 : ucs_pkg::PH_DEAD;
        end
        ucs_pkg::PH_SEP2: begin
          phase_next = (feed_char == ucs_pkg::CH_SLASH) ? ucs_pkg::PH_HOST : ucs_pkg::PH_DEAD;
        end
        ucs_pkg::PH_HOST: begin
          byte_after_separator_next = 1'b1;
          if (feed_char == ucs_pkg::CH_SLASH) begin
            phase_next = ucs_pkg::PH_PATH;
          end else if (feed_char == ucs_pkg::CH_QUEST) begin
            phase_next = ucs_pkg::PH_QUERY;
          end else if (feed_char == ucs_pkg::CH_HASH) begin
            phase_next = ucs_pkg::PH_FRAG;
          end else begin
            work.has_data  = 1'b1;
            work.comp      = ucs_pkg::COMP_HOST;
          end
        end
        ucs_pkg::PH_PATH: begin
          byte_after_separator_next = 1'b1;
          if (feed_char == ucs_pkg::CH_QUEST) begin
            phase_next = ucs_pkg::PH_QUERY;
          end else if (feed_char == ucs_pkg::CH_HASH) begin
            phase_next = ucs_pkg::PH_FRAG;
          end else begin
            work.has_data = 1'b1;
            work.comp     = ucs_pkg::COMP_PATH;
          end
        end
        ucs_pkg::PH_QUERY: begin
          byte_after_separator_next = 1'b1;
          if (feed_char == ucs_pkg::CH_HASH) begin
            phase_next = ucs_pkg::PH_FRAG;
          end else begin
            work.has_data = 1'b1;
            work.comp     = ucs_pkg::COMP_QUERY;
          end
        end
        ucs_pkg::PH_FRAG: begin
          byte_after_separator_next = 1'b1;
          work.has_data = 1'b1;
          work.comp     = ucs_pkg::COMP_FRAG;
        end
        default: begin
        end
      endcase
    end
    work.data_byte = feed_char;

    // closing status and return to reset
    if (item.end_of_url) begin
      if (escape_step_next != ucs_pkg::ESC_IDLE) begin
        error_seen_next  = 1'b1;
        escape_step_next = ucs_pkg::ESC_IDLE;
        phase_next       = ucs_pkg::PH_DEAD;
      end
      valid = !error_seen_next && byte_after_separator_next &&
              (phase_next inside {ucs_pkg::PH_HOST, ucs_pkg::PH_PATH,
                                  ucs_pkg::PH_QUERY, ucs_pkg::PH_FRAG});
      work.has_status    = 1'b1;
      work.status_valid  = valid;
      work.status_scheme = valid ? matched_scheme_next : ucs_pkg::SCHEME_NONE;
      phase_next                = ucs_pkg::PH_SCHEME;
      scheme_position_next      = 4'd0;
      scheme_candidates_next    = 3'b111;
      escape_step_next          = ucs_pkg::ESC_IDLE;
      high_nibble_next          = 4'd0;
      error_seen_next           = 1'b0;
      matched_scheme_next       = ucs_pkg::SCHEME_NONE;
      byte_after_separator_next = 1'b0;
    end
    work_wr = step && (work.has_data || work.has_status);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= ucs_pkg::PH_SCHEME;
      scheme_position      <= 4'd0;
      scheme_candidates    <= 3'b111;
      escape_step          <= ucs_pkg::ESC_IDLE;
      high_nibble          <= 4'd0;
      error_seen           <= 1'b0;
      matched_scheme       <= ucs_pkg::SCHEME_NONE;
      byte_after_separator <= 1'b0;
    end else if (step) begin
      phase                <= phase_next;
      scheme_position      <= scheme_position_next;
      scheme_candidates    <= scheme_candidates_next;
      escape_step          <= escape_step_next;
      high_nibble          <= high_nibble_next;
      error_seen           <= error_seen_next;
      matched_scheme       <= matched_scheme_next;
      byte_after_separator <= byte_after_separator_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ucs_queue.sv
// short register queue of front-end work entries
`default_nettype none
module ucs_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire ucs_pkg::ucs_work_t wr_data,
  output logic                    full,
  input  wire logic               rd_en,
  output ucs_pkg::ucs_work_t      rd_data,
  output logic                    empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  ucs_pkg::ucs_work_t slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full    = (count == FULL_COUNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ucs_back.sv
// back end: turns each work entry into its data and status results
`default_nettype none
module ucs_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ucs_pkg::ucs_work_t q_data,
  input  wire logic               q_empty,
  output logic                    q_rd,
  output ucs_pkg::ucs_result_t    result,
  output logic                    empty,
  input  wire logic               pop
);

  ucs_pkg::ucs_work_t cur;
  logic cur_valid;
  logic data_done;
  logic show_data;
  logic finishing;

  assign show_data = cur.has_data && !data_done;
  assign finishing = pop && cur_valid && !(show_data && cur.has_status);
  assign q_rd      = !q_empty && (!cur_valid || finishing);
  assign empty     = !cur_valid;

  always_comb begin
    result = '0;
    if (show_data) begin
      result.out_byte  = cur.data_byte;
      result.component = cur.comp;
    end else begin
      result.is_status   = 1'b1;
      result.url_valid   = cur.status_valid;
      result.scheme_code = cur.status_scheme;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      data_done <= 1'b0;
    end else if (q_rd) begin
      cur_valid <= 1'b1;
      data_done <= 1'b0;
    end else if (finishing) begin
      cur_valid <= 1'b0;
      data_done <= 1'b0;
    end else if (pop && cur_valid) begin
      data_done <= 1'b1;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/url_component_splitter.sv
// top level of the url component splitter
// an accepted byte's entry is queued, then loaded into the back end's cur register
// throughput: one byte per cycle unless full; a closing byte that also carries data
// gives two results, drained by the back end while the front end keeps accepting
// reset: synchronous, active high; clears parser state, queue and output stage
`default_nettype none
module url_component_splitter #(
  parameter int DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire ucs_pkg::ucs_item_t   item,
  output logic                      empty,
  input  wire logic                 pop,
  output ucs_pkg::ucs_result_t      result
);

  ucs_pkg::ucs_work_t work, q_data;
  logic work_wr, q_rd, q_empty, step;

  assign step = push && !full;

  ucs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .item    (item),
    .work    (work),
    .work_wr (work_wr)
  );

  ucs_queue #(.DEPTH(DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (work_wr),
    .wr_data (work),
    .full    (full),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  ucs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_data),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule
`default_nettype wire

### hw/rtl/ucs_checker.sv
// port-level checks for the url component splitter, bound to the top level
`default_nettype none
module ucs_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 full,
  input wire logic                 empty,
  input wire logic                 pop,
  input wire ucs_pkg::ucs_result_t result
);

  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("result or full flag left over after reset");

  a_data_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.is_status) |-> (!result.url_valid &&
                                       result.scheme_code == ucs_pkg::SCHEME_NONE))
    else $error("status fields set on a data transaction");

  a_status_scheme: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.is_status) |->
      (result.url_valid == (result.scheme_code != ucs_pkg::SCHEME_NONE)))
    else $error("status validity and scheme disagree");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.is_status) |->
      (result.out_byte == 8'h00 && result.component == ucs_pkg::COMP_HOST))
    else $error("status transaction carries data");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting transaction changed or vanished");

endmodule

bind url_component_splitter ucs_checker u_ucs_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
`default_nettype wire
